FILE: design/sbfr_pkg.sv
`timescale 1ns / 1ps

package sbfr_pkg;

    // Operation codes of an input word
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Event codes of a result word
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_DATA   = 2'd1;
    localparam logic [1:0] EV_QUERY  = 2'd2;
    localparam logic [1:0] EV_STATUS = 2'd3;

    // Framing bytes
    localparam logic [7:0] START_DATA   = 8'h7F;
    localparam logic [7:0] START_STATUS = 8'h06;
    localparam logic [7:0] END_MARK     = 8'hF7;

    // Payload that marks a sensor query: "IRSEN"
    localparam logic [7:0] QUERY_B0 = 8'h49;
    localparam logic [7:0] QUERY_B1 = 8'h52;
    localparam logic [7:0] QUERY_B2 = 8'h53;
    localparam logic [7:0] QUERY_B3 = 8'h45;
    localparam logic [7:0] QUERY_B4 = 8'h4E;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1855;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] payload_byte0;
        logic [7:0] payload_byte1;
        logic [7:0] payload_byte2;
        logic [7:0] payload_byte3;
        logic [7:0] payload_byte4;
        logic [7:0] status_byte;
    } out_item_t;

endpackage

FILE: design/seven_byte_frame_receiver_unit.sv
`timescale 1ns / 1ps

// Receive-side deframer for a serial link.
// The s_ channel carries input words: either one received byte or one
// microsecond tick, chosen by the operation field. Every accepted byte gives
// exactly one word on the m_ channel (event code, the five stored payload
// bytes and the stored status byte); a tick gives none and only advances the
// elapsed-time counter, which saturates at its top value.
// The cfg_ channel writes the frame timeout in ticks; it is always ready and
// should only be used while no word is in flight.
// Timing: a word is captured in the input register, then parsed and written
// to the result register once the result slot is free, so a byte passes
// both registers before m_valid rises. One word is taken every cycle unless
// a byte waits on a stalled result; the only loop is the parser state.
// When the receiver stalls m_ready, the result is held and the input
// register still takes one further word; ticks keep flowing past a stalled
// result since they need no output slot.
// Synchronous reset clears the valid flags of both registers, the parser
// to idle, the elapsed counter and stores to zero, the timeout to 1855 ticks.

module seven_byte_frame_receiver_unit
    import sbfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic        in_valid_reg, in_valid_next;
    in_item_t    in_item_reg;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_item_reg;
    logic [15:0] timeout_reg;
    logic        advance;
    logic        is_tick;
    out_item_t   parse_result;

    // The input word moves on when it is a tick, or when the result slot
    // is free or being emptied in this cycle.
    assign is_tick = (in_item_reg.operation == OP_TICK);
    assign advance = in_valid_reg && (is_tick || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign in_valid_next = s_ready ? s_valid : in_valid_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (advance && !is_tick) begin
            out_valid_next = 1'b1;
        end
    end

    sbfr_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (advance),
        .item          (in_item_reg),
        .timeout_ticks (timeout_reg),
        .result        (parse_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            timeout_reg   <= TIMEOUT_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                timeout_reg <= cfg_data;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
        if (advance && !is_tick) begin
            out_item_reg <= parse_result;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_item_reg;

    // Reset empties the result slot.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A parsed byte always lands in the result register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !is_tick) |=> m_valid)
        else $error("parsed byte produced no result");

    // A tick never creates a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && is_tick && !out_valid_reg) |=> !m_valid)
        else $error("tick produced a result");

    // A held input word is never overwritten.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |-> !s_ready)
        else $error("input register overwritten while held");

endmodule

FILE: design/sbfr_parser.sv
`timescale 1ns / 1ps

module sbfr_parser
    import sbfr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step_en,
    input  in_item_t  item,
    input  logic [15:0] timeout_ticks,
    output out_item_t result
);

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_PAY1       = 4'd1;
    localparam logic [3:0] ST_PAY2       = 4'd2;
    localparam logic [3:0] ST_PAY3       = 4'd3;
    localparam logic [3:0] ST_PAY4       = 4'd4;
    localparam logic [3:0] ST_PAY5       = 4'd5;
    localparam logic [3:0] ST_END        = 4'd6;
    localparam logic [3:0] ST_STATUS     = 4'd7;
    localparam logic [3:0] ST_STATUS_END = 4'd8;

    logic [3:0]  state_reg,   state_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [7:0]  pay_reg [5];
    logic [7:0]  pay_next [5];
    logic [7:0]  status_reg,  status_next;
    logic [1:0]  event_next;
    logic [3:0]  cur_state;
    logic        is_query;

    assign is_query = (pay_reg[0] == QUERY_B0) && (pay_reg[1] == QUERY_B1)
                   && (pay_reg[2] == QUERY_B2) && (pay_reg[3] == QUERY_B3)
                   && (pay_reg[4] == QUERY_B4);

    always_comb begin
        state_next   = state_reg;
        elapsed_next = elapsed_reg;
        pay_next     = pay_reg;
        status_next  = status_reg;
        event_next   = EV_NONE;
        cur_state    = state_reg;
        if (item.operation == OP_TICK) begin
            if (elapsed_reg != TICK_MAX) begin
                elapsed_next = elapsed_reg + 16'd1;
            end
        end else begin
            // An unfinished frame that has run too long is dropped first.
            if (elapsed_reg > timeout_ticks) begin
                cur_state = ST_IDLE;
            end
            case (cur_state)
                ST_PAY1: begin
                    pay_next[0] = item.rx_byte;
                    state_next  = ST_PAY2;
                end
                ST_PAY2: begin
                    pay_next[1] = item.rx_byte;
                    state_next  = ST_PAY3;
                end
                ST_PAY3: begin
                    pay_next[2] = item.rx_byte;
                    state_next  = ST_PAY4;
                end
                ST_PAY4: begin
                    pay_next[3] = item.rx_byte;
                    state_next  = ST_PAY5;
                end
                ST_PAY5: begin
                    pay_next[4] = item.rx_byte;
                    state_next  = ST_END;
                end
                ST_END: begin
                    if (item.rx_byte == END_MARK) begin
                        event_next = is_query ? EV_QUERY : EV_DATA;
                    end
                    state_next = ST_IDLE;
                end
                ST_STATUS: begin
                    status_next = item.rx_byte;
                    state_next  = ST_STATUS_END;
                end
                ST_STATUS_END: begin
                    if (item.rx_byte == END_MARK) begin
                        event_next = EV_STATUS;
                    end
                    state_next = ST_IDLE;
                end
                default: begin
                    // Idle, and any unused code, hunts for a start byte.
                    state_next = ST_IDLE;
                    if (item.rx_byte == START_DATA) begin
                        state_next   = ST_PAY1;
                        elapsed_next = 16'd0;
                    end else if (item.rx_byte == START_STATUS) begin
                        state_next   = ST_STATUS;
                        elapsed_next = 16'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            elapsed_reg <= 16'd0;
            pay_reg     <= '{default: 8'd0};
            status_reg  <= 8'd0;
        end else if (step_en) begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
            pay_reg     <= pay_next;
            status_reg  <= status_next;
        end
    end

    assign result.event_res     = event_next;
    assign result.payload_byte0 = pay_next[0];
    assign result.payload_byte1 = pay_next[1];
    assign result.payload_byte2 = pay_next[2];
    assign result.payload_byte3 = pay_next[3];
    assign result.payload_byte4 = pay_next[4];
    assign result.status_byte   = status_next;

endmodule

FILE: dv/seven_byte_frame_receiver_unit_test.sv
`timescale 1ns / 1ps

module seven_byte_frame_receiver_unit_test;
    import sbfr_pkg::*;

    // Parser positions, in the order in which a frame is walked.
    typedef enum logic [3:0] {
        PS_IDLE       = 4'd0,
        PS_PAY1       = 4'd1,
        PS_PAY2       = 4'd2,
        PS_PAY3       = 4'd3,
        PS_PAY4       = 4'd4,
        PS_PAY5       = 4'd5,
        PS_DATA_END   = 4'd6,
        PS_STATUS     = 4'd7,
        PS_STATUS_END = 4'd8
    } parse_state_t;

    // One row of the directed sequence. Where typed is set, the result word
    // written in the row is what the block must give, in place of the
    // predicted one.
    typedef struct {
        logic       op;
        logic [7:0] b;
        bit         typed;
        out_item_t  want;
    } directed_row_t;

    localparam int N_DIRECTED = 23;
    localparam int N_PHASES   = 7;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_item;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // Our own copy of the deframer state and of its timeout register.
    parse_state_t parse_state;
    logic [15:0]  tick_count;
    logic [7:0]   payload_mem [5];
    logic [7:0]   status_mem;
    logic [15:0]  timeout_lim;

    logic [7:0]   query_word [5];
    out_item_t    pending_results [$];
    int           error_count;
    int           byte_count;

    // Idling controls shared between the stimulus and the receiver process.
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;
    int hold_left;

    directed_row_t directed_rows [N_DIRECTED];
    logic [15:0]   timeout_plan [N_PHASES];

    seven_byte_frame_receiver_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // A tick only advances the elapsed counter, which sticks at its top value.
    function automatic void count_tick();
        if (tick_count != TICK_MAX) begin
            tick_count = tick_count + 16'd1;
        end
    endfunction

    // Works out the result word of one received byte and moves the parser on.
    // The timeout is checked first, whatever the parser is doing.
    function automatic out_item_t deframe_byte(input logic [7:0] b);
        out_item_t  r;
        logic [1:0] ev;
        bit         is_query;
        ev = EV_NONE;
        if (tick_count > timeout_lim) begin
            parse_state = PS_IDLE;
        end
        case (parse_state)
            PS_PAY1, PS_PAY2, PS_PAY3, PS_PAY4, PS_PAY5: begin
                payload_mem[parse_state - PS_PAY1] = b;
                parse_state = parse_state_t'(parse_state + 4'd1);
            end
            PS_DATA_END: begin
                is_query = 1'b1;
                for (int i = 0; i < 5; i++) begin
                    if (payload_mem[i] != query_word[i]) begin
                        is_query = 1'b0;
                    end
                end
                // A wrong end byte throws the frame away but keeps the stores.
                if (b == END_MARK) begin
                    ev = is_query ? EV_QUERY : EV_DATA;
                end
                parse_state = PS_IDLE;
            end
            PS_STATUS: begin
                status_mem = b;
                parse_state = PS_STATUS_END;
            end
            PS_STATUS_END: begin
                if (b == END_MARK) begin
                    ev = EV_STATUS;
                end
                parse_state = PS_IDLE;
            end
            default: begin
                parse_state = PS_IDLE;
                if (b == START_DATA) begin
                    parse_state = PS_PAY1;
                    tick_count = '0;
                end else if (b == START_STATUS) begin
                    parse_state = PS_STATUS;
                    tick_count = '0;
                end
            end
        endcase
        r.event_res     = ev;
        r.payload_byte0 = payload_mem[0];
        r.payload_byte1 = payload_mem[1];
        r.payload_byte2 = payload_mem[2];
        r.payload_byte3 = payload_mem[3];
        r.payload_byte4 = payload_mem[4];
        r.status_byte   = status_mem;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    // Offers one word, idling first as the current setting asks, and updates
    // the prediction once the block has taken it.
    task automatic push_word(input in_item_t w, input bit typed, input out_item_t typed_want);
        out_item_t want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= w;
        do @(posedge aclk); while (!s_ready);
        if (w.operation == OP_TICK) begin
            count_tick();
        end else begin
            want = deframe_byte(w.rx_byte);
            if (typed) begin
                want = typed_want;
            end
            pending_results.push_back(want);
            byte_count++;
        end
    endtask

    task automatic send_ticks(input int n);
        in_item_t w;
        repeat (n) begin
            w.operation = OP_TICK;
            w.rx_byte   = 8'($urandom_range(0, 255));
            push_word(w, 1'b0, '0);
        end
    endtask

    // Ticks between two bytes of a frame. Now and then the gap is sized to
    // land just on or just past the timeout, so that both sides are seen.
    task automatic tick_gap(input bit clean);
        int r;
        int n;
        n = 0;
        if (!clean) begin
            r = $urandom_range(0, 99);
            if (r >= 50 && r < 85) begin
                n = $urandom_range(1, 3);
            end else if (r >= 85 && r < 97) begin
                n = (timeout_lim <= 16'd32) ? $urandom_range(0, int'(timeout_lim) + 1)
                                            : $urandom_range(4, 10);
            end else if (r >= 97 && timeout_lim <= 16'd32) begin
                n = int'(timeout_lim) + $urandom_range(0, 1);
            end
        end
        send_ticks(n);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit clean);
        in_item_t w;
        tick_gap(clean);
        w.operation = OP_BYTE;
        w.rx_byte   = b;
        push_word(w, 1'b0, '0);
    endtask

    // Random byte, leaning now and then towards the framing values and the
    // two extremes.
    function automatic logic [7:0] rand_byte();
        logic [7:0] special [5];
        special = '{START_DATA, START_STATUS, END_MARK, 8'h00, 8'hFF};
        if ($urandom_range(0, 99) < 15) begin
            return special[$urandom_range(0, 4)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly well formed frames with random content; the rest is cut-off
    // frames and loose bytes.
    task automatic send_traffic(input int n_bytes);
        int         first;
        int         kind;
        int         flavour;
        int         flip_idx;
        bit         clean;
        logic [7:0] b;
        first = byte_count;
        while (byte_count - first < n_bytes) begin
            kind  = $urandom_range(0, 99);
            clean = $urandom_range(0, 1);
            if (kind < 45) begin
                flavour  = $urandom_range(0, 99);
                flip_idx = $urandom_range(0, 4);
                send_byte(START_DATA, clean);
                for (int i = 0; i < 5; i++) begin
                    if (flavour < 25) begin
                        b = query_word[i];
                    end else if (flavour < 35) begin
                        b = (i == flip_idx) ? query_word[i] ^ (8'd1 << $urandom_range(0, 7))
                                            : query_word[i];
                    end else begin
                        b = rand_byte();
                    end
                    send_byte(b, clean);
                end
                send_byte(($urandom_range(0, 99) < 85) ? END_MARK : rand_byte(), clean);
            end else if (kind < 70) begin
                send_byte(START_STATUS, clean);
                send_byte(rand_byte(), clean);
                send_byte(($urandom_range(0, 99) < 85) ? END_MARK : rand_byte(), clean);
            end else if (kind < 85) begin
                send_byte($urandom_range(0, 1) ? START_DATA : START_STATUS, clean);
                repeat ($urandom_range(0, 3)) send_byte(rand_byte(), clean);
            end else begin
                repeat ($urandom_range(1, 4)) send_byte(rand_byte(), 1'b0);
            end
        end
    endtask

    // Waits for every expected word, with a bound, then a few more cycles
    // so that a tick still in the pipeline has been taken in as well.
    task automatic settle();
        int waited;
        s_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_timeout(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        timeout_lim = v;
    endtask

    // Result checker: every word taken from the block is held against the
    // oldest expectation.
    initial begin
        out_item_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result word with nothing expected: %0h", m_item);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("event_res", 8'(want.event_res), 8'(m_item.event_res));
                    compare_field("payload_byte0", want.payload_byte0, m_item.payload_byte0);
                    compare_field("payload_byte1", want.payload_byte1, m_item.payload_byte1);
                    compare_field("payload_byte2", want.payload_byte2, m_item.payload_byte2);
                    compare_field("payload_byte3", want.payload_byte3, m_item.payload_byte3);
                    compare_field("payload_byte4", want.payload_byte4, m_item.payload_byte4);
                    compare_field("status_byte", want.status_byte, m_item.status_byte);
                end
            end
        end
    end

    // Receiver side. A hold-off request keeps m_ready low for a long run of
    // cycles, so that the block fills and has to stall its input.
    initial begin
        m_ready   = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 300;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_item        = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        hold_req      = 1'b0;
        error_count   = 0;
        byte_count    = 0;
        send_idle_pct = 22;
        recv_idle_pct = 66;

        query_word = '{QUERY_B0, QUERY_B1, QUERY_B2, QUERY_B3, QUERY_B4};
        parse_state = PS_IDLE;
        tick_count  = '0;
        status_mem  = '0;
        timeout_lim = TIMEOUT_RESET;
        for (int i = 0; i < 5; i++) begin
            payload_mem[i] = '0;
        end

        // Loose bytes straight after reset, a data frame with extreme payload
        // bytes and a tick inside it, the sensor query, a status frame and a
        // status frame with a wrong end byte.
        directed_rows = '{
            '{OP_BYTE, 8'h00, 1'b1, '{EV_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
            '{OP_BYTE, 8'hFF, 1'b1, '{EV_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
            '{OP_BYTE, START_DATA, 1'b0, '0},
            '{OP_BYTE, 8'hFF, 1'b0, '0},
            '{OP_BYTE, 8'h00, 1'b0, '0},
            '{OP_BYTE, 8'hAA, 1'b0, '0},
            '{OP_BYTE, 8'h55, 1'b0, '0},
            '{OP_TICK, 8'hFF, 1'b0, '0},
            '{OP_BYTE, 8'h80, 1'b0, '0},
            '{OP_BYTE, END_MARK, 1'b1,
              '{EV_DATA, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h80, 8'h00}},
            '{OP_BYTE, START_DATA, 1'b0, '0},
            '{OP_BYTE, QUERY_B0, 1'b0, '0},
            '{OP_BYTE, QUERY_B1, 1'b0, '0},
            '{OP_BYTE, QUERY_B2, 1'b0, '0},
            '{OP_BYTE, QUERY_B3, 1'b0, '0},
            '{OP_BYTE, QUERY_B4, 1'b0, '0},
            '{OP_BYTE, END_MARK, 1'b1,
              '{EV_QUERY, QUERY_B0, QUERY_B1, QUERY_B2, QUERY_B3, QUERY_B4, 8'h00}},
            '{OP_BYTE, START_STATUS, 1'b0, '0},
            '{OP_BYTE, 8'hA5, 1'b0, '0},
            '{OP_BYTE, END_MARK, 1'b1,
              '{EV_STATUS, QUERY_B0, QUERY_B1, QUERY_B2, QUERY_B3, QUERY_B4, 8'hA5}},
            '{OP_BYTE, START_STATUS, 1'b0, '0},
            '{OP_BYTE, 8'h00, 1'b0, '0},
            '{OP_BYTE, 8'h00, 1'b0, '0}
        };

        // Timeout settings by phase; the first two run with the sender
        // idling less than the receiver, the next two the other way round,
        // and the rest with no idling at all.
        timeout_plan = '{16'd0, 16'd3, 16'd65534, 16'd17, TIMEOUT_RESET, 16'd65534, 16'd1};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            push_word('{directed_rows[i].op, directed_rows[i].b},
                      directed_rows[i].typed, directed_rows[i].want);
        end
        settle();

        for (int p = 0; p < N_PHASES; p++) begin
            if (p < 2) begin
                send_idle_pct = 22;
                recv_idle_pct = 66;
            end else if (p < 4) begin
                send_idle_pct = 66;
                recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_timeout(timeout_plan[p]);
            if (p == 4) begin
                hold_req = 1'b1;
            end
            send_traffic(35);
            settle();
        end

        if (pending_results.size() != 0) begin
            $error("%0d expected result words never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
